[src/assert_macros.svh]
// Assertion macros shared by the offset generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/cgog_pkg.sv]
// Package with widths, register codes and shared types of the offset generator.
`timescale 1ns / 1ps

package cgog_pkg;

   localparam int IDX_W        = 24;
   localparam int DIM_W        = 13;
   localparam int STRIDE_W     = 5;
   localparam int BSTRIDE_W    = 31;
   localparam int CSR_DATA_W   = 31;
   localparam int CSR_INDEX_W  = 3;
   localparam int NPIX_W       = 2 * DIM_W;
   localparam int NVALID_W     = 3 * DIM_W;
   localparam int OFFSET_WIDTH = 32;
   localparam int RSP_W        = 32;

   typedef logic [OFFSET_WIDTH-1:0] offset_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IN_WIDTH,
      CSR_OUT_WIDTH,
      CSR_OUT_HEIGHT,
      CSR_BATCH_COUNT,
      CSR_STRIDE_W,
      CSR_STRIDE_H,
      CSR_IN_BATCH_STRIDE,
      CSR_OUT_BATCH_STRIDE
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]     in_width;
      logic [DIM_W-1:0]     out_width;
      logic [DIM_W-1:0]     out_height;
      logic [DIM_W-1:0]     batch_count;
      logic [STRIDE_W-1:0]  stride_w;
      logic [STRIDE_W-1:0]  stride_h;
      logic [BSTRIDE_W-1:0] in_batch_stride;
      logic [BSTRIDE_W-1:0] out_batch_stride;
   } cfg_type;

   // Per-item sideband carried alongside the divider stages.
   typedef struct packed {
      logic             pad;
      logic [IDX_W-1:0] img;
      logic [IDX_W-1:0] pix;
   } div_side_type;

   typedef struct packed {
      logic [RSP_W-1:0] in_offset;
      logic [RSP_W-1:0] out_offset;
      logic             is_padding;
   } rsp_type;

   localparam cfg_type CFG_RESET = '{
      in_width:         DIM_W'(1),
      out_width:        DIM_W'(1),
      out_height:       DIM_W'(1),
      batch_count:      DIM_W'(1),
      stride_w:         STRIDE_W'(1),
      stride_h:         STRIDE_W'(1),
      in_batch_stride:  BSTRIDE_W'(0),
      out_batch_stride: BSTRIDE_W'(0)
   };

endpackage

[src/cgog_divider.sv]
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module cgog_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic [cgog_pkg::IDX_W-1:0]     in_dividend,
   input  logic [cgog_pkg::NPIX_W-1:0]    in_divisor,
   input  cgog_pkg::div_side_type         in_side,
   output logic                           out_valid,
   output logic [cgog_pkg::IDX_W-1:0]     out_quotient,
   output logic [cgog_pkg::IDX_W-1:0]     out_remainder,
   output cgog_pkg::div_side_type         out_side
);

   localparam int IW = cgog_pkg::IDX_W;
   localparam int TW = cgog_pkg::NPIX_W + 1;

   // The word register shifts the dividend out at the top while quotient
   // bits enter at the bottom; after the last stage it holds the quotient.
   logic                   valid_ff [IW];
   logic [IW-1:0]          word_ff  [IW];
   logic [IW-1:0]          rem_ff   [IW];
   cgog_pkg::div_side_type side_ff  [IW];

   for (genvar k = 0; k < IW; k++) begin : g_stage
      logic [IW-1:0]          word_src;
      logic [IW-1:0]          rem_src;
      logic                   valid_src;
      cgog_pkg::div_side_type side_src;
      logic [IW:0]            trial;
      logic [TW-1:0]          diff;
      logic                   take;
      logic [IW-1:0]          word_in;
      logic [IW-1:0]          rem_in;

      if (k == 0) begin : g_first
         assign word_src  = in_dividend;
         assign rem_src   = '0;
         assign valid_src = in_valid;
         assign side_src  = in_side;
      end else begin : g_next
         assign word_src  = word_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign valid_src = valid_ff[k-1];
         assign side_src  = side_ff[k-1];
      end

      // A zero divisor only occurs with a zero dividend; it yields zeros.
      assign trial   = {rem_src, word_src[IW-1]};
      assign diff    = TW'(trial) - TW'(in_divisor);
      assign take    = (in_divisor != '0) && (TW'(trial) >= TW'(in_divisor));
      assign rem_in  = take ? diff[IW-1:0] : trial[IW-1:0];
      assign word_in = {word_src[IW-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            word_ff[k] <= word_in;
            rem_ff[k]  <= rem_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid     = valid_ff[IW-1];
   assign out_quotient  = word_ff[IW-1];
   assign out_remainder = rem_ff[IW-1];
   assign out_side      = side_ff[IW-1];

endmodule

[src/cgog_offset_calc.sv]
// Four-stage multiply-add pipeline that forms the input and output byte offsets.
`timescale 1ns / 1ps

module cgog_offset_calc (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  cgog_pkg::div_side_type       in_side,
   input  logic [cgog_pkg::IDX_W-1:0]   in_row,
   input  logic [cgog_pkg::DIM_W-1:0]   in_col,
   input  cgog_pkg::cfg_type            cfg,
   output logic                         out_valid,
   output cgog_pkg::rsp_type            out_rsp
);

   localparam int OW   = cgog_pkg::OFFSET_WIDTH;
   localparam int RW   = cgog_pkg::RSP_W;
   localparam int IW   = cgog_pkg::IDX_W;
   localparam int PA_W = cgog_pkg::IDX_W + cgog_pkg::BSTRIDE_W;
   localparam int PB_W = cgog_pkg::STRIDE_W + cgog_pkg::IDX_W;
   localparam int PC_W = cgog_pkg::STRIDE_W + cgog_pkg::DIM_W;
   localparam int PM_W = OW + cgog_pkg::DIM_W;

   logic m1_valid_ff, m2_valid_ff, m3_valid_ff, m4_valid_ff;

   logic [PA_W-1:0] m1_pa_ff, m1_pa_in;
   logic [PA_W-1:0] m1_po_ff, m1_po_in;
   logic [PB_W-1:0] m1_pb_ff, m1_pb_in;
   logic [PC_W-1:0] m1_pc_ff, m1_pc_in;
   logic [IW-1:0]   m1_pix_ff;
   logic            m1_pad_ff;

   cgog_pkg::offset_type m2_sum_ff, m2_sum_in;
   cgog_pkg::offset_type m2_oo_ff, m2_oo_in, m2_oo_sum;
   logic [PC_W-1:0]      m2_pc_ff;
   logic                 m2_pad_ff;

   cgog_pkg::offset_type m3_prod_ff, m3_prod_in;
   cgog_pkg::offset_type m3_oo_ff;
   logic [PC_W-1:0]      m3_pc_ff;
   logic                 m3_pad_ff;

   cgog_pkg::offset_type m4_io_ff, m4_io_in, m4_io_sum;
   cgog_pkg::offset_type m4_oo_ff;
   logic                 m4_pad_ff;

   always_comb begin
      m1_pa_in   = PA_W'(in_side.img) * PA_W'(cfg.in_batch_stride);
      m1_po_in   = PA_W'(in_side.img) * PA_W'(cfg.out_batch_stride);
      m1_pb_in   = PB_W'(cfg.stride_h) * PB_W'(in_row);
      m1_pc_in   = PC_W'(cfg.stride_w) * PC_W'(in_col);
      m2_sum_in  = OW'(m1_pa_ff) + OW'(m1_pb_ff);
      m2_oo_sum  = OW'(m1_po_ff) + OW'(m1_pix_ff);
      m2_oo_in   = m2_oo_sum << 2;
      m3_prod_in = OW'(PM_W'(m2_sum_ff) * PM_W'(cfg.in_width));
      m4_io_sum  = m3_prod_ff + OW'(m3_pc_ff);
      m4_io_in   = m4_io_sum << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
         m4_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= in_valid;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
         m4_valid_ff <= m3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_pa_ff   <= m1_pa_in;
         m1_po_ff   <= m1_po_in;
         m1_pb_ff   <= m1_pb_in;
         m1_pc_ff   <= m1_pc_in;
         m1_pix_ff  <= in_side.pix;
         m1_pad_ff  <= in_side.pad;
         m2_sum_ff  <= m2_sum_in;
         m2_oo_ff   <= m2_oo_in;
         m2_pc_ff   <= m1_pc_ff;
         m2_pad_ff  <= m1_pad_ff;
         m3_prod_ff <= m3_prod_in;
         m3_oo_ff   <= m2_oo_ff;
         m3_pc_ff   <= m2_pc_ff;
         m3_pad_ff  <= m2_pad_ff;
         m4_io_ff   <= m4_io_in;
         m4_oo_ff   <= m3_oo_ff;
         m4_pad_ff  <= m3_pad_ff;
      end
   end

   assign out_valid          = m4_valid_ff;
   assign out_rsp.in_offset  = RW'(m4_io_ff);
   assign out_rsp.out_offset = RW'(m4_oo_ff);
   assign out_rsp.is_padding = m4_pad_ff;

endmodule

[src/cgog_out_buf.sv]
// Output register with a skid entry; a full skid entry holds the pipeline.
`timescale 1ns / 1ps

module cgog_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  cgog_pkg::rsp_type in_rsp,
   output logic              hold,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cgog_pkg::rsp_type rsp_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   cgog_pkg::rsp_type out_data_ff, out_data_in;
   cgog_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              push;
   logic              open;

   // The pipeline moves only while the skid entry is empty.
   assign push = in_valid && !skid_valid_ff;
   assign open = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (open) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : in_rsp;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign hold      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[src/conv_gemm_offset_generator.sv]
// Top level of the implicit-GEMM offset generator for strided convolution.
// Path: stages A, B and C, the image and row dividers, the offset pipeline and the output register.
// Throughput: one word per cycle while the output skid entry is empty, set by the bit-per-stage divider pipelines.
// Stalls: a full skid entry at the output holds every stage; nothing is lost.
// Reset: synchronous, active high; clears all valid bits and loads register defaults.
// Register writes settle the derived plane and batch sizes through cfg_ff, then npix_ff, then nvalid_ff.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module conv_gemm_offset_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [cgog_pkg::IDX_W-1:0]         req_position_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [cgog_pkg::RSP_W-1:0]         rsp_in_offset,
   output logic [cgog_pkg::RSP_W-1:0]         rsp_out_offset,
   output logic                               rsp_is_padding,
   input  logic                               csr_write,
   input  logic [cgog_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cgog_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int IW  = cgog_pkg::IDX_W;
   localparam int DW  = cgog_pkg::DIM_W;
   localparam int SW  = cgog_pkg::STRIDE_W;
   localparam int BW  = cgog_pkg::BSTRIDE_W;
   localparam int PW  = cgog_pkg::NPIX_W;
   localparam int VW  = cgog_pkg::NVALID_W;

   // Configuration registers. Writes are only expected while the block is idle,
   // so every stage reads them directly.
   cgog_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (cgog_pkg::csr_index_type'(csr_index))
            cgog_pkg::CSR_IN_WIDTH:         cfg_in.in_width         = csr_data[DW-1:0];
            cgog_pkg::CSR_OUT_WIDTH:        cfg_in.out_width        = csr_data[DW-1:0];
            cgog_pkg::CSR_OUT_HEIGHT:       cfg_in.out_height       = csr_data[DW-1:0];
            cgog_pkg::CSR_BATCH_COUNT:      cfg_in.batch_count      = csr_data[DW-1:0];
            cgog_pkg::CSR_STRIDE_W:         cfg_in.stride_w         = csr_data[SW-1:0];
            cgog_pkg::CSR_STRIDE_H:         cfg_in.stride_h         = csr_data[SW-1:0];
            cgog_pkg::CSR_IN_BATCH_STRIDE:  cfg_in.in_batch_stride  = csr_data[BW-1:0];
            cgog_pkg::CSR_OUT_BATCH_STRIDE: cfg_in.out_batch_stride = csr_data[BW-1:0];
         endcase
      end
   end

   // Pixels per image and the exact count of valid indexes, one multiply per
   // register so each settles in the cycle after its operands.
   logic [PW-1:0] npix_ff;
   logic [VW-1:0] nvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= cgog_pkg::CFG_RESET;
         npix_ff   <= PW'(1);
         nvalid_ff <= VW'(1);
      end else begin
         cfg_ff    <= cfg_in;
         npix_ff   <= PW'(cfg_ff.out_width) * PW'(cfg_ff.out_height);
         nvalid_ff <= VW'(cfg_ff.batch_count) * VW'(npix_ff);
      end
   end

   // One enable for the whole pipeline: it advances whenever the skid entry
   // at the output is empty. The stall seen upstream is that same register.
   logic advance;
   logic hold;

   assign advance   = !hold;
   assign req_stall = hold;

   // Front stages. Stage A takes the word, stage B only delays it so that the
   // derived sizes are settled after a write, and stage C does the range check.
   // An index out of range becomes index 0 and is flagged as padding.
   logic          a_valid_ff, b_valid_ff, c_valid_ff;
   logic [IW-1:0] a_idx_ff, b_idx_ff, c_eff_ff, c_eff_in;
   logic          c_pad_ff, c_pad_in;

   always_comb begin
      c_pad_in = !(VW'(b_idx_ff) < nvalid_ff);
      c_eff_in = c_pad_in ? '0 : b_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_idx_ff <= req_position_index;
         b_idx_ff <= a_idx_ff;
         c_eff_ff <= c_eff_in;
         c_pad_ff <= c_pad_in;
      end
   end

   // First divider: image number and pixel within the image.
   cgog_pkg::div_side_type d1_side_in, d1_side;
   logic                   d1_valid;
   logic [IW-1:0]          d1_img, d1_pix;

   assign d1_side_in.pad = c_pad_ff;
   assign d1_side_in.img = '0;
   assign d1_side_in.pix = '0;

   cgog_divider u_div_image (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (c_valid_ff),
      .in_dividend   (c_eff_ff),
      .in_divisor    (npix_ff),
      .in_side       (d1_side_in),
      .out_valid     (d1_valid),
      .out_quotient  (d1_img),
      .out_remainder (d1_pix),
      .out_side      (d1_side)
   );

   // Second divider: row and column within the output plane. The column is
   // below out_width, so its low bits carry the whole value.
   cgog_pkg::div_side_type d2_side_in, d2_side;
   logic                   d2_valid;
   logic [IW-1:0]          d2_row, d2_col;

   assign d2_side_in.pad = d1_side.pad;
   assign d2_side_in.img = d1_img;
   assign d2_side_in.pix = d1_pix;

   cgog_divider u_div_row (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (d1_valid),
      .in_dividend   (d1_pix),
      .in_divisor    (PW'(cfg_ff.out_width)),
      .in_side       (d2_side_in),
      .out_valid     (d2_valid),
      .out_quotient  (d2_row),
      .out_remainder (d2_col),
      .out_side      (d2_side)
   );

   // Offset arithmetic, wrapping at the offset width.
   logic              calc_valid;
   cgog_pkg::rsp_type calc_rsp;

   cgog_offset_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d2_valid),
      .in_side   (d2_side),
      .in_row    (d2_row),
      .in_col    (d2_col[DW-1:0]),
      .cfg       (cfg_ff),
      .out_valid (calc_valid),
      .out_rsp   (calc_rsp)
   );

   // Output register plus skid entry between the pipeline and the consumer.
   cgog_pkg::rsp_type rsp_data;

   cgog_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (calc_valid),
      .in_rsp    (calc_rsp),
      .hold      (hold),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_in_offset  = rsp_data.in_offset;
   assign rsp_out_offset = rsp_data.out_offset;
   assign rsp_is_padding = rsp_data.is_padding;

   // The skid entry only fills behind a held output word.
   `ASSERT_IMPL(a_stall_needs_output, clock, reset, req_stall, rsp_valid, "input stalled with no output word held")
   // A padding position maps to index 0, so both offsets must be zero.
   `ASSERT_IMPL(a_padding_zero, clock, reset, rsp_valid && rsp_is_padding, (rsp_in_offset == '0) && (rsp_out_offset == '0), "padding word with nonzero offset")
   // An accepted word must occupy the first stage on the next cycle.
   `ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, a_valid_ff, "accepted word missing from the first stage")

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the implicit-GEMM convolution offset generator.
`timescale 1ns / 1ps

module testbench;
   import cgog_pkg::*;

   // The drain at the end waits beyond the block's response delay so that any
   // stray word would still be seen.
   localparam int LATENCY      = 55;
   // Register writes settle the derived plane and batch sizes through
   // registers, so requests are held back after a write burst until they settle.
   localparam int SETTLE       = 4;
   // Roughly ten times the slowest legal run: about 2000 words, each behind
   // the longest request gap and the longest result stall, plus the phase drains.
   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASE_WORDS  = 250;

   logic                   clock;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic [IDX_W-1:0]       req_position_index = '0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic [RSP_W-1:0]       rsp_in_offset;
   logic [RSP_W-1:0]       rsp_out_offset;
   logic                   rsp_is_padding;
   logic                   csr_write          = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index          = '0;
   logic [CSR_DATA_W-1:0]  csr_data           = '0;

   // Shadow copy of the geometry registers, updated at each write edge.
   cfg_type geometry = CFG_RESET;
   // Offset words still owed by the block, oldest first.
   rsp_type pending_offsets[$];

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int          stall_left  = 0;
   // Random gaps on the request side and stalls on the result side; cleared
   // for the final stretch so the block also runs at full rate.
   bit          idle_on     = 1'b1;

   conv_gemm_offset_generator DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_position_index (req_position_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_in_offset      (rsp_in_offset),
      .rsp_out_offset     (rsp_out_offset),
      .rsp_is_padding     (rsp_is_padding),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Computes the offset pair for one position under the shadow geometry.
   // All products are formed in 64 bits; the low bits of a 64-bit wrap are the
   // same as those of the exact value, so cutting to the port width is enough.
   function automatic rsp_type predict_offsets(input logic [IDX_W-1:0] position);
      logic [63:0] plane;
      logic [63:0] valid_count;
      logic [63:0] flat;
      logic [63:0] img;
      logic [63:0] pix;
      logic [63:0] row;
      logic [63:0] col;
      logic [63:0] in_off;
      logic [63:0] out_off;
      rsp_type     result;
      plane       = 64'(geometry.out_width) * 64'(geometry.out_height);
      valid_count = 64'(geometry.batch_count) * plane;
      // Positions past the batch, and every position when the plane or the
      // batch is empty, collapse onto position zero and are flagged.
      result.is_padding = !(64'(position) < valid_count);
      flat = result.is_padding ? 64'd0 : 64'(position);
      img  = '0;
      pix  = '0;
      row  = '0;
      col  = '0;
      if (plane != 0) begin
         img = flat / plane;
         pix = flat % plane;
         row = pix / 64'(geometry.out_width);
         col = pix % 64'(geometry.out_width);
      end
      in_off  = ((img * 64'(geometry.in_batch_stride) + 64'(geometry.stride_h) * row)
                 * 64'(geometry.in_width) + 64'(geometry.stride_w) * col) << 2;
      out_off = (img * 64'(geometry.out_batch_stride) + pix) << 2;
      result.in_offset  = in_off[RSP_W-1:0];
      result.out_offset = out_off[RSP_W-1:0];
      return result;
   endfunction

   // Picks a position: mostly inside the valid range, some right at its edge,
   // and some anywhere in the 24-bit field so that every bit toggles.
   function automatic logic [IDX_W-1:0] pick_position();
      logic [63:0] span;
      logic [63:0] pick;
      span = 64'(geometry.batch_count) * 64'(geometry.out_width)
             * 64'(geometry.out_height);
      if (span > 64'h00FF_FFFF)
         span = 64'h0100_0000;
      case ($urandom_range(0, 9))
         0, 1: pick = 64'($urandom);
         2: pick = span + 64'($urandom_range(0, 2)) - 64'd1;
         default: begin
            if (span == 0)
               pick = 64'($urandom);
            else
               pick = 64'($urandom_range(0, 32'(span - 1)));
         end
      endcase
      return pick[IDX_W-1:0];
   endfunction

   // Geometry families used by the random phases.
   function automatic cfg_type random_geometry(input int flavor);
      logic [127:0] noise;
      cfg_type      g;
      noise = {$urandom, $urandom, $urandom, $urandom};
      g     = noise[$bits(cfg_type)-1:0];
      case (flavor)
         // Small planes, so that whole images and batch wraps are crossed often.
         1: begin
            g.in_width         = DIM_W'($urandom_range(1, 8));
            g.out_width        = DIM_W'($urandom_range(1, 8));
            g.out_height       = DIM_W'($urandom_range(1, 8));
            g.batch_count      = DIM_W'($urandom_range(1, 6));
            g.stride_w         = STRIDE_W'($urandom_range(1, 4));
            g.stride_h         = STRIDE_W'($urandom_range(1, 4));
            g.in_batch_stride  = BSTRIDE_W'($urandom_range(0, 255));
            g.out_batch_stride = BSTRIDE_W'($urandom_range(0, 255));
         end
         // Medium planes with batch strides big enough to wrap the offsets.
         2: begin
            g.in_width         = DIM_W'($urandom_range(1, 96));
            g.out_width        = DIM_W'($urandom_range(1, 96));
            g.out_height       = DIM_W'($urandom_range(1, 96));
            g.batch_count      = DIM_W'($urandom_range(1, 32));
            g.stride_w         = STRIDE_W'($urandom_range(1, 16));
            g.stride_h         = STRIDE_W'($urandom_range(1, 16));
            g.in_batch_stride  = BSTRIDE_W'($urandom_range(0, 32'h4000_0000));
            g.out_batch_stride = BSTRIDE_W'($urandom_range(0, 32'h4000_0000));
         end
         // Every register at the top of its bit width.
         3: g = '1;
         // Every register cleared: empty plane, empty batch, zero strides.
         4: g = '0;
         // The largest values the software is expected to program.
         5: begin
            g.in_width         = DIM_W'(4096);
            g.out_width        = DIM_W'(4096);
            g.out_height       = DIM_W'(4096);
            g.batch_count      = DIM_W'(4096);
            g.stride_w         = STRIDE_W'(16);
            g.stride_h         = STRIDE_W'(16);
            g.in_batch_stride  = BSTRIDE_W'(32'h4000_0000);
            g.out_batch_stride = BSTRIDE_W'(32'h4000_0000);
         end
         // Anything else keeps the raw noise: any value within the widths.
         default: ;
      endcase
      return g;
   endfunction

   // Offers one position word and waits until the block takes it. The valid
   // is left high on return; the next call or the drain decides its fate, so
   // valid never sees two assignments in one time step.
   task automatic send_position(input logic [IDX_W-1:0] position);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_position_index <= position;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_offsets.insert(pending_offsets.size(), predict_offsets(position));
   endtask

   // Stops offering words and waits until every owed result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_offsets.size() != 0)
         @(posedge clock);
   endtask

   // Writes one register. Bits above the register's width carry random junk,
   // which the block must drop; the shadow copy keeps only the low bits.
   task automatic write_reg(input csr_index_type which,
                            input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] keep;
      logic [CSR_DATA_W-1:0] data;
      int                    bits;
      case (which)
         CSR_STRIDE_W, CSR_STRIDE_H: bits = STRIDE_W;
         CSR_IN_BATCH_STRIDE, CSR_OUT_BATCH_STRIDE: bits = BSTRIDE_W;
         default: bits = DIM_W;
      endcase
      keep = (CSR_DATA_W'(1) << bits) - CSR_DATA_W'(1);
      data = (value & keep) | (CSR_DATA_W'($urandom) & ~keep);
      csr_write <= 1'b1;
      csr_index <= which;
      csr_data  <= data;
      @(posedge clock);
      case (which)
         CSR_IN_WIDTH:         geometry.in_width         = data[DIM_W-1:0];
         CSR_OUT_WIDTH:        geometry.out_width        = data[DIM_W-1:0];
         CSR_OUT_HEIGHT:       geometry.out_height       = data[DIM_W-1:0];
         CSR_BATCH_COUNT:      geometry.batch_count      = data[DIM_W-1:0];
         CSR_STRIDE_W:         geometry.stride_w         = data[STRIDE_W-1:0];
         CSR_STRIDE_H:         geometry.stride_h         = data[STRIDE_W-1:0];
         CSR_IN_BATCH_STRIDE:  geometry.in_batch_stride  = data[BSTRIDE_W-1:0];
         CSR_OUT_BATCH_STRIDE: geometry.out_batch_stride = data[BSTRIDE_W-1:0];
      endcase
   endtask

   // Programs a whole geometry. The block is drained first, so no word in
   // flight can see a half-written set of registers.
   task automatic load_geometry(input cfg_type g);
      wait_drained();
      write_reg(CSR_IN_WIDTH,         CSR_DATA_W'(g.in_width));
      write_reg(CSR_OUT_WIDTH,        CSR_DATA_W'(g.out_width));
      write_reg(CSR_OUT_HEIGHT,       CSR_DATA_W'(g.out_height));
      write_reg(CSR_BATCH_COUNT,      CSR_DATA_W'(g.batch_count));
      write_reg(CSR_STRIDE_W,         CSR_DATA_W'(g.stride_w));
      write_reg(CSR_STRIDE_H,         CSR_DATA_W'(g.stride_h));
      write_reg(CSR_IN_BATCH_STRIDE,  CSR_DATA_W'(g.in_batch_stride));
      write_reg(CSR_OUT_BATCH_STRIDE, CSR_DATA_W'(g.out_batch_stride));
      csr_write <= 1'b0;
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register defaults: a one-pixel plane and a batch of one, so only
   // position zero is valid and everything else is padding.
   task automatic test_reset_defaults();
      send_position(IDX_W'(0));
      send_position(IDX_W'(1));
      send_position('1);
   endtask

   // A hand-sized 5x3 plane with four images: first pixel, row and image
   // boundaries, the last valid position and the first ones past it.
   task automatic test_small_geometry();
      cfg_type g;
      g = '{in_width: 7, out_width: 5, out_height: 3, batch_count: 4,
            stride_w: 2, stride_h: 3, in_batch_stride: 100, out_batch_stride: 200};
      load_geometry(g);
      send_position(IDX_W'(0));
      send_position(IDX_W'(4));
      send_position(IDX_W'(5));
      send_position(IDX_W'(14));
      send_position(IDX_W'(15));
      send_position(IDX_W'(59));
      send_position(IDX_W'(60));
      send_position(IDX_W'(61));
   endtask

   // A plane with zero width, then one with zero height: all padding, and
   // both offsets must come out zero.
   task automatic test_empty_plane();
      cfg_type g;
      g = '{in_width: 9, out_width: 0, out_height: 4, batch_count: 3,
            stride_w: 2, stride_h: 2, in_batch_stride: 50, out_batch_stride: 70};
      load_geometry(g);
      send_position(IDX_W'(0));
      send_position(IDX_W'(2));
      g.out_width  = 6;
      g.out_height = 0;
      load_geometry(g);
      send_position(IDX_W'(0));
   endtask

   // An empty batch: every position maps onto position zero.
   task automatic test_zero_batch();
      cfg_type g;
      g = '{in_width: 9, out_width: 4, out_height: 4, batch_count: 0,
            stride_w: 3, stride_h: 1, in_batch_stride: 11, out_batch_stride: 13};
      load_geometry(g);
      send_position(IDX_W'(0));
      send_position(IDX_W'(7));
   endtask

   // Every register at its widest: the valid range covers the whole index
   // field, and the products wrap well past 32 bits.
   task automatic test_wide_extremes();
      load_geometry('1);
      send_position('1);
      send_position(IDX_W'(24'hAAAAAA));
      send_position(IDX_W'(24'h555555));
   endtask

   // The bulk of the run: one phase per geometry family, the small-plane family
   // twice, with random gaps and stalls on both channels.
   task automatic test_random_geometries();
      int flavors[7] = '{1, 2, 0, 3, 5, 4, 1};
      foreach (flavors[p]) begin
         load_geometry(random_geometry(flavors[p]));
         repeat (PHASE_WORDS) send_position(pick_position());
      end
   endtask

   // The last stretch streams back to back with no gaps and no stalls.
   task automatic test_unthrottled_stream();
      wait_drained();
      idle_on <= 1'b0;
      load_geometry(random_geometry(2));
      repeat (PHASE_WORDS) send_position(pick_position());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_small_geometry();
      test_empty_plane();
      test_zero_batch();
      test_wide_extremes();
      test_random_geometries();
      test_unthrottled_stream();
      wait_drained();
      // Anything the block still emits now has no expectation and fails.
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Result-side back-pressure in random bursts. The register changes only
   // at clock edges, so the block and the checker below both see the value
   // from before the edge.
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string field, input logic [RSP_W-1:0] want,
                              input logic [RSP_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("time %0t: %s mismatch, expected %h, actual %h",
                  $time, field, want, got);
      end
   endtask

   // Every accepted result word is matched against the oldest owed word.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_offsets.size() == 0) begin
            error_count++;
            $display("time %0t: unexpected result word, expected none, actual %h %h %b",
                     $time, rsp_in_offset, rsp_out_offset, rsp_is_padding);
         end else begin
            want = pending_offsets.pop_front();
            check_field("in_offset",  want.in_offset,  rsp_in_offset);
            check_field("out_offset", want.out_offset, rsp_out_offset);
            check_field("is_padding", RSP_W'(want.is_padding), RSP_W'(rsp_is_padding));
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("time %0t: timeout with %0d result words owed",
                  $time, pending_offsets.size());
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule

[sim.f]
+incdir+src
src/cgog_pkg.sv
src/cgog_divider.sv
src/cgog_offset_calc.sv
src/cgog_out_buf.sv
src/conv_gemm_offset_generator.sv
tb/sv/testbench.sv
